// ===== src/permutation_keystream_xor_cipher_macros.svh =====
// Assertion macros shared by the cipher checker.
`ifndef PERMUTATION_KEYSTREAM_XOR_CIPHER_MACROS_SVH
`define PERMUTATION_KEYSTREAM_XOR_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during rst.
`define PKXC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, idle during rst.
`define PKXC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pkxc_pkg.sv =====
// Shared constants and types for the permutation keystream cipher.
`timescale 1ns / 1ps
`default_nettype none

package pkxc_pkg;

  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam int BYTE_W            = 8;
  localparam int KEY_W             = 64;
  localparam int LEN_W             = 4;

  localparam logic [LEN_W-1:0] KEY_LEN_RESET = 4'd8;

  typedef logic [BYTE_W-1:0] byte_t;

  // Configuration register indexes
  typedef enum logic {
    REG_KEY_BYTES = 1'b0,
    REG_KEY_LEN   = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== src/pkxc_perm_unit.sv =====
// Working key store and sequencer that steps it to its next permutation.
`timescale 1ns / 1ps
`default_nettype none

module pkxc_perm_unit import pkxc_pkg::*; #(
  parameter int  MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int IDXW          = $clog2(MAX_KEY_BYTES),
  localparam int CNTW          = $clog2(MAX_KEY_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [KEY_W-1:0] key_bytes,
  input  logic             start,
  input  logic [CNTW-1:0]  len,
  input  logic [IDXW-1:0]  rd_addr,
  output byte_t            rd_data,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOLD,
    S_SCAN,
    S_FINDQ,
    S_SW_RD,
    S_SW_X,
    S_SW_WR,
    S_REV_CHK
  } state_t;

  state_t          state;
  byte_t           wk [MAX_KEY_BYTES];
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] last_idx;
  logic [IDXW-1:0] pivot;
  logic [IDXW-1:0] lo;
  logic [IDXW-1:0] hi;
  byte_t           hold;
  byte_t           pval;
  byte_t           tmp;
  logic            pivot_swap;

  logic [IDXW-1:0] ra;
  byte_t           rdv;
  byte_t           cmp_a;
  byte_t           cmp_b;
  logic            lt;

  // Single read port, address picked by the sequencer step
  always_comb begin
    unique case (state) inside
      S_IDLE:                  ra = rd_addr;
      S_HOLD, S_SCAN, S_FINDQ: ra = idx;
      S_SW_X:                  ra = hi;
      default:                 ra = lo;
    endcase
  end

  assign rdv     = wk[ra];
  assign rd_data = rdv;

  // Shared byte comparator: descent search, then successor search
  always_comb begin
    if (state == S_SCAN) begin
      cmp_a = rdv;
      cmp_b = hold;
    end else begin
      cmp_a = pval;
      cmp_b = rdv;
    end
  end

  assign lt   = (cmp_a < cmp_b);
  assign busy = (state != S_IDLE);

  // Sequencer and key store
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pivot_swap <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (load) begin
            for (int k = 0; k < MAX_KEY_BYTES; k++) begin
              wk[k] <= key_bytes[BYTE_W*k +: BYTE_W];
            end
          end
          if (start) begin
            idx      <= IDXW'(len - CNTW'(1));
            last_idx <= IDXW'(len - CNTW'(1));
            state    <= S_HOLD;
          end
        end
        S_HOLD: begin
          hold  <= rdv;
          idx   <= idx - 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (lt) begin
            pivot <= idx;
            pval  <= rdv;
            idx   <= last_idx;
            state <= S_FINDQ;
          end else begin
            hold <= rdv;
            if (idx == '0) begin
              // fully descending: reverse the whole block
              lo    <= '0;
              hi    <= last_idx;
              state <= S_REV_CHK;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        S_FINDQ: begin
          if (lt) begin
            lo         <= pivot;
            hi         <= idx;
            pivot_swap <= 1'b1;
            state      <= S_SW_RD;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_SW_RD: begin
          tmp   <= rdv;
          state <= S_SW_X;
        end
        S_SW_X: begin
          wk[hi] <= tmp;
          tmp    <= rdv;
          state  <= S_SW_WR;
        end
        S_SW_WR: begin
          wk[lo] <= tmp;
          if (pivot_swap) begin
            lo         <= pivot + 1'b1;
            hi         <= last_idx;
            pivot_swap <= 1'b0;
          end else begin
            lo <= lo + 1'b1;
            hi <= hi - 1'b1;
          end
          state <= S_REV_CHK;
        end
        S_REV_CHK: begin
          state <= (lo < hi) ? S_SW_RD : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/permutation_keystream_xor_cipher.sv =====
// Top level: byte channel control, key registers and keystream position.
//
// Usage: message bytes enter on data_byte/last with in_valid; an input
// transfer happens when in_valid is high and in_stall is low. Each byte
// yields one cipher_byte on out_valid, taken when out_stall is low.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 key_bytes,
// 1 key_len); write only while no byte is in flight.
// Flow: a byte inside a keystream block is first held in the byte register,
// then its result is loaded into the output register, which raises out_valid;
// the next byte can be taken once that result is loaded. The first byte of a
// block also waits for the permutation sequencer, whose single read port and
// comparator step the working key.
// One byte is in work at a time; in_stall stays high until its result is
// loaded into the output register, which may still be waiting on the
// receiver while the next byte is taken.
// Reset: key_bytes clears, key_len returns to 8, the position goes to zero
// and the next byte reloads the key. A stalled receiver holds cipher_byte
// and, once a second result is ready, holds the block in in_stall.
`timescale 1ns / 1ps
`default_nettype none

module permutation_keystream_xor_cipher import pkxc_pkg::*; #(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  byte_t            data_byte,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_stall,
  output byte_t            cipher_byte,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [KEY_W-1:0] cfg_data
);

  localparam int IDXW = $clog2(MAX_KEY_BYTES);
  localparam int CNTW = $clog2(MAX_KEY_BYTES + 1);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t           state;
  logic [KEY_W-1:0] key_bytes;
  logic [LEN_W-1:0] key_len;
  logic [IDXW-1:0]  pos;
  logic             reload_pending;
  logic [CNTW-1:0]  n_r;
  byte_t            data_r;
  logic             last_r;
  logic             bypass;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic [CNTW-1:0]  n_sat;
  logic [IDXW-1:0]  pos_eff;
  logic             perm_start;
  logic             key_load;
  logic [CNTW-1:0]  pos_inc;
  logic             wrap;
  byte_t            ks;
  logic             perm_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes <= '0;
      key_len   <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_BYTES: key_bytes <= cfg_data;
        REG_KEY_LEN:   key_len   <= cfg_data[LEN_W-1:0];
        default:       key_len   <= key_len;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_BUSY) && !perm_busy && out_free;

  // Clamp the key length to the store size
  assign n_sat = (key_len > LEN_W'(MAX_KEY_BYTES)) ? CNTW'(MAX_KEY_BYTES)
                                                   : CNTW'(key_len);

  // Restart the block on reload or when the length no longer exceeds the position
  assign pos_eff    = (reload_pending || (CNTW'(pos) >= n_sat)) ? '0 : pos;
  assign key_load   = accept && (n_sat != '0) && reload_pending;
  assign perm_start = accept && (n_sat >= CNTW'(2)) && (pos_eff == '0);

  assign pos_inc = CNTW'(pos) + CNTW'(1);
  assign wrap    = (pos_inc >= n_r);

  pkxc_perm_unit #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_perm (
    .clk       (clk),
    .rst       (rst),
    .load      (key_load),
    .key_bytes (key_bytes),
    .start     (perm_start),
    .len       (n_sat),
    .rd_addr   (pos),
    .rd_data   (ks),
    .busy      (perm_busy)
  );

  // Byte control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      pos            <= '0;
      reload_pending <= 1'b1;
    end else begin
      // Load a finished result, drop one the receiver took
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            data_r <= data_byte;
            last_r <= last;
            n_r    <= n_sat;
            bypass <= (n_sat == '0);
            if (n_sat != '0) begin
              pos            <= pos_eff;
              reload_pending <= 1'b0;
            end
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (out_load) begin
            if (bypass) begin
              cipher_byte <= data_r;
            end else begin
              cipher_byte <= data_r ^ ks;
              pos         <= (wrap || last_r) ? '0 : IDXW'(pos_inc);
            end
            if (last_r) begin
              reload_pending <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/pkxc_checker.sv =====
// Port-level checker for the cipher top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "permutation_keystream_xor_cipher_macros.svh"

module pkxc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cipher_byte
);

  // One byte at a time: a transfer closes the input until its result is out
  `PKXC_ASSERT_NXT(a_busy_after_xfer, in_valid && !in_stall, in_stall, "input open after transfer")

  // Input reopens only when a result sits in the output register
  `PKXC_ASSERT_IMP(a_result_on_release, $fell(in_stall), out_valid, "input reopened without a result")

  // Stalled result stays valid
  `PKXC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

  // Stalled result keeps its value
  `PKXC_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(cipher_byte), "stalled result changed")

endmodule

bind permutation_keystream_xor_cipher pkxc_checker u_pkxc_checker (.*);

`default_nettype wire
